[sv/l2nq_pkg.sv]
// Shared types, constants and helpers of the L2 normalize and quantize encoder.
`default_nettype none

package l2nq_pkg;

  localparam int SUM_W  = 64;
  localparam int NORM_W = 46;
  localparam int RAD_W  = 92;
  localparam int SREM_W = 48;
  localparam int CNT_W  = 13;
  localparam int POW_W  = 30;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_SKIPPED  = 2'd3;

  localparam logic [1:0] REG_VECTOR_LENGTH  = 2'd0;
  localparam logic [1:0] REG_SCALE_EXPONENT = 2'd1;
  localparam logic [1:0] REG_MODULUS        = 2'd2;
  localparam logic [1:0] REG_INVERT_ORDER   = 2'd3;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic sqrt_init;
    logic sqrt_step;
    logic sqrt_last;
    logic div_init;
    logic div_step;
    logic rnd;
    logic fin;
  } l2nq_cmd_t;

  typedef struct packed {
    logic mode;
    logic norm_ready;
    logic skip;
    logic out_free;
  } l2nq_stat_t;

  function automatic logic [POW_W-1:0] pow10(input logic [3:0] e);
    logic [POW_W-1:0] p;
    unique case (e)
      4'd0: p = 30'd1;
      4'd1: p = 30'd10;
      4'd2: p = 30'd100;
      4'd3: p = 30'd1000;
      4'd4: p = 30'd10000;
      4'd5: p = 30'd100000;
      4'd6: p = 30'd1000000;
      4'd7: p = 30'd10000000;
      4'd8: p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

[sv/l2nq_ctrl.sv]
// Sequencer of the encoder: accept, multiply, square root and division steps, result.
`default_nettype none

module l2nq_ctrl import l2nq_pkg::*; #(
  parameter int NUM_W = 70
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire l2nq_stat_t stat,
  output l2nq_cmd_t       cmd
);

  localparam int IT_W = $clog2(NUM_W);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_ACC  = 8'b0000_0100,
    S_SQRT = 8'b0000_1000,
    S_PREP = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_RND  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t          state, state_next;
  logic [IT_W-1:0] iter, iter_next;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (!stat.mode) begin
          state_next = S_ACC;
        end else if (stat.norm_ready) begin
          state_next = S_PREP;
        end else begin
          cmd.sqrt_init = 1'b1;
          iter_next     = IT_W'(NORM_W - 1);
          state_next    = S_SQRT;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_IDLE;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (iter == '0) begin
          cmd.sqrt_last = 1'b1;
          state_next    = S_PREP;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_PREP: begin
        if (stat.skip) begin
          state_next = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          iter_next    = IT_W'(NUM_W - 1);
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (iter == '0) begin
          state_next = S_RND;
        end else begin
          iter_next = iter - 1'b1;
        end
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

endmodule

`default_nettype wire

[sv/l2nq_datapath.sv]
// Datapath of the encoder: registers, multiplier, square root and divider steps, output register.
`default_nettype none

module l2nq_datapath import l2nq_pkg::*; #(
  parameter int PT_SIZE        = 4096,
  parameter int COMPONENT_BITS = 24,
  parameter int NUM_W          = 70
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic                      mode,
  input  wire logic [COMPONENT_BITS-1:0] component,
  input  wire l2nq_cmd_t                 cmd,
  output l2nq_stat_t                     stat,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [31:0]                    coefficient,
  output logic [11:0]                    slot,
  output logic [1:0]                     status,
  output logic                           last
);

  localparam int B      = COMPONENT_BITS;
  localparam int PROD_W = B + POW_W;
  localparam int SW     = $clog2(PT_SIZE);

  logic [12:0]       vector_length;
  logic [3:0]        scale_exponent;
  logic [31:0]       modulus;
  logic              invert_order;

  logic              mode_r;
  logic              neg;
  logic [B-1:0]      mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sq_acc;
  logic [NORM_W-1:0] norm_value;
  logic [NORM_W-1:0] root;
  logic [RAD_W-1:0]  srad;
  logic [SREM_W-1:0] srem;
  logic [NUM_W-1:0]  quo;
  logic [NORM_W-1:0] drem;
  logic [NUM_W:0]    qr;
  logic [CNT_W-1:0]  item_count;
  logic [SW-1:0]     slot_idx;
  logic              norm_ready;
  logic              overflow_seen;

  logic [B-1:0]        mag_in;
  logic [POW_W-1:0]    mul_b;
  logic [12:0]         len;
  logic                is_last;
  logic [SREM_W+1:0]   srem_t;
  logic [SREM_W+1:0]   strial;
  logic                sge;
  logic [NORM_W-1:0]   root_next;
  logic [NORM_W:0]     drem_t;
  logic                dge;
  logic [NORM_W:0]     rnd_lhs;
  logic                ovf;
  logic [31:0]         slot_full;
  logic [CNT_W-1:0]    acc_base;
  logic [CNT_W-1:0]    acc_inc;
  logic [SW-1:0]       acc_slot;
  logic [SUM_W-1:0]    sum_base;
  logic [1:0]          status_next;
  logic [31:0]         coef_next;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (32'(s) == 32'(PT_SIZE - 1)) ? '0 : s + 1'b1;
  endfunction

  assign mag_in    = component[B-1] ? (~component + 1'b1) : component;
  assign mul_b     = mode_r ? pow10(scale_exponent) : POW_W'(mag);
  assign len       = (vector_length == '0) ? 13'd1 : vector_length;
  assign is_last   = (14'(item_count) + 14'd1) >= 14'(len);

  assign srem_t    = {srem, srad[RAD_W-1 -: 2]};
  assign strial    = (SREM_W+2)'({root, 2'b01});
  assign sge       = srem_t >= strial;
  assign root_next = {root[NORM_W-2:0], sge};

  assign drem_t    = {drem, quo[NUM_W-1]};
  assign dge       = drem_t >= {1'b0, norm_value};
  assign rnd_lhs   = {drem, 1'b0};

  assign ovf       = qr > (NUM_W+1)'(modulus[31:1]);
  assign slot_full = invert_order ? (32'(PT_SIZE - 1) - 32'(slot_idx)) : 32'(slot_idx);

  assign acc_base  = norm_ready ? '0 : item_count;
  assign acc_inc   = acc_base + 1'b1;
  assign acc_slot  = norm_ready ? '0 : slot_idx;
  assign sum_base  = (norm_ready || item_count == '0) ? '0 : sq_acc;

  always_comb begin
    coef_next = '0;
    if (norm_value == '0) begin
      status_next = ST_ZERO;
    end else if (overflow_seen) begin
      status_next = ST_SKIPPED;
    end else if (ovf) begin
      status_next = ST_OVERFLOW;
    end else begin
      status_next = ST_OK;
      coef_next   = (neg && qr != '0) ? (modulus - qr[31:0]) : qr[31:0];
    end
  end

  assign stat.mode       = mode_r;
  assign stat.norm_ready = norm_ready;
  assign stat.skip       = (norm_value == '0) || overflow_seen;
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length  <= 13'd4096;
      scale_exponent <= 4'd2;
      modulus        <= 32'd65537;
      invert_order   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VECTOR_LENGTH:  vector_length  <= cfg_data[12:0];
        REG_SCALE_EXPONENT: scale_exponent <= cfg_data[3:0];
        REG_MODULUS:        modulus        <= cfg_data;
        REG_INVERT_ORDER:   invert_order   <= cfg_data[0];
        default:            invert_order   <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      neg    <= component[B-1];
      mag    <= mag_in;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mag) * PROD_W'(mul_b);
    end
    if (cmd.sqrt_init) begin
      srad <= {sq_acc[RAD_W-33:0], 32'b0};
      srem <= '0;
      root <= '0;
    end
    if (cmd.sqrt_step) begin
      srad <= {srad[RAD_W-3:0], 2'b00};
      srem <= sge ? SREM_W'(srem_t - strial) : srem_t[SREM_W-1:0];
      root <= root_next;
    end
    if (cmd.div_init) begin
      quo  <= {prod, 16'b0};
      drem <= '0;
    end
    if (cmd.div_step) begin
      quo  <= {quo[NUM_W-2:0], dge};
      drem <= dge ? NORM_W'(drem_t - {1'b0, norm_value}) : drem_t[NORM_W-1:0];
    end
    if (cmd.rnd) begin
      qr <= {1'b0, quo} + (NUM_W+1)'(rnd_lhs >= {1'b0, norm_value});
    end
    if (cmd.fin) begin
      coefficient <= coef_next;
      slot        <= slot_full[11:0];
      status      <= status_next;
      last        <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_acc        <= '0;
      norm_value    <= '0;
      item_count    <= '0;
      slot_idx      <= '0;
      norm_ready    <= 1'b0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.acc) begin
        norm_ready    <= 1'b0;
        overflow_seen <= 1'b0;
        sq_acc        <= sum_base + SUM_W'(prod);
        if (14'(acc_inc) >= 14'(len)) begin
          item_count <= '0;
          slot_idx   <= '0;
        end else begin
          item_count <= acc_inc;
          slot_idx   <= slot_inc(acc_slot);
        end
      end
      if (cmd.sqrt_last) begin
        norm_value    <= root_next;
        norm_ready    <= 1'b1;
        overflow_seen <= 1'b0;
        item_count    <= '0;
        slot_idx      <= '0;
      end
      if (cmd.fin) begin
        out_valid <= 1'b1;
        if (status_next == ST_OVERFLOW) begin
          overflow_seen <= 1'b1;
        end
        if (is_last) begin
          item_count    <= '0;
          slot_idx      <= '0;
          norm_ready    <= 1'b0;
          overflow_seen <= 1'b0;
          sq_acc        <= '0;
        end else begin
          item_count <= item_count + 1'b1;
          slot_idx   <= slot_inc(slot_idx);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[sv/l2_normalize_quantize_encoder_core.sv]
// Top level of the L2 normalize and quantize encoder.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_index, cfg_data
//   in       in         in_valid / in_ready   mode, component
//   out      out        out_valid / out_ready coefficient, slot, status, last
//
// A mode 0 item is accepted, squared and accumulated.
// A mode 1 item is scaled and divided by the norm, one quotient bit per cycle,
// then rounded; the first item of a pass first takes the square root.
// An item whose norm is zero or that follows an overflow skips the divider.
// Reset is synchronous; a finished result waits in the output register while
// the next item is accepted, and only its write waits for out_ready.
`default_nettype none

module l2_normalize_quantize_encoder_core import l2nq_pkg::*; #(
  parameter int PT_SIZE        = 4096,
  parameter int COMPONENT_BITS = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      mode,
  input  wire logic [COMPONENT_BITS-1:0] component,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [31:0]                    coefficient,
  output logic [11:0]                    slot,
  output logic [1:0]                     status,
  output logic                           last
);

  localparam int NUM_W = COMPONENT_BITS + POW_W + 16;

  l2nq_cmd_t  cmd;
  l2nq_stat_t stat;

  l2nq_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  l2nq_datapath #(
    .PT_SIZE        (PT_SIZE),
    .COMPONENT_BITS (COMPONENT_BITS),
    .NUM_W          (NUM_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .component   (component),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .coefficient (coefficient),
    .slot        (slot),
    .status      (status),
    .last        (last)
  );

endmodule

`default_nettype wire
